// ===== sv/irht_pkg.sv =====
// ----------------------------------------------------------------------------
// irht_pkg: shared definitions of the identifier remap hash table
// Table geometry, field widths, hash constants, status codes and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package irht_pkg;

    localparam int CAPACITY   = 4096;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int ID_W       = ADDR_W - 1;
    localparam int KEY_W      = 63;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = 1 + ID_W + KEY_W;

    localparam int HASH_SHIFT = 33;
    localparam logic [63:0] HASH_MUL = 64'hff51afd7ed558ccd;

    // Only the low ADDR_W + HASH_SHIFT bits of the product reach the slot index.
    localparam int MUL_W = ADDR_W + HASH_SHIFT;
    localparam int LO_W  = (MUL_W + 1) / 2;
    localparam int HI_W  = MUL_W - LO_W;
    localparam logic [LO_W-1:0] MUL_LO = HASH_MUL[LO_W-1:0];
    localparam logic [HI_W-1:0] MUL_HI = HASH_MUL[MUL_W-1:LO_W];

    localparam int STEP_W     = 2;
    localparam int HASH_STEPS = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic clear_wr;
        logic load_key;
        logic hash_step;
        logic seed;
        logic issue;
        logic resolve;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic used;
        logic hit;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/irht_ram.sv =====
// ----------------------------------------------------------------------------
// irht_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module irht_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/irht_datapath.sv =====
// ----------------------------------------------------------------------------
// irht_datapath: hash, probe and result datapath
// Holds the key, computes the slot hash stepwise with one shared multiplier,
// walks the slot memory and keeps the dense id counter and the output
// register.
// ----------------------------------------------------------------------------
module irht_datapath
    import irht_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                s_operation,
    input  logic [KEY_W-1:0]    s_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_dense_id
);

    logic [KEY_W-1:0]    key_reg;
    logic                insert_reg;
    logic [MUL_W-1:0]    x_reg;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [MUL_W-1:0]    acc_reg, acc_next;
    logic [ADDR_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]   last_addr_reg;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   next_id_reg, next_id_next;
    status_t             res_status_reg;
    logic [ID_W-1:0]     res_id_reg;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_W-1:0]     out_id_reg;

    logic [63:0]         key_ext;
    logic [LO_W-1:0]     mul_a, mul_b;
    logic [2*LO_W-1:0]   prod;
    logic [MUL_W-1:0]    prod_w, prod_sh;
    logic [ADDR_W-1:0]   home;
    logic [ADDR_W-1:0]   rd_addr;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic                rd_used;
    logic [ID_W-1:0]     rd_id;
    logic [KEY_W-1:0]    rd_key;
    logic                full;
    logic                ins_ok;

    assign key_ext = {1'b0, s_key};

    always_comb begin
        case (step_reg)
            2'd0: begin
                mul_a = x_reg[LO_W-1:0];
                mul_b = MUL_LO;
            end
            2'd1: begin
                mul_a = x_reg[LO_W-1:0];
                mul_b = LO_W'(MUL_HI);
            end
            default: begin
                mul_a = LO_W'(x_reg[MUL_W-1:LO_W]);
                mul_b = MUL_LO;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod_w  = prod[MUL_W-1:0];
    assign prod_sh = {prod_w[MUL_W-LO_W-1:0], {LO_W{1'b0}}};

    always_comb begin
        acc_next = acc_reg;
        if (cmd.hash_step) begin
            if (step_reg == '0) begin
                acc_next = prod_w;
            end else begin
                acc_next = acc_reg + prod_sh;
            end
        end
    end

    assign step_next = cmd.load_key  ? '0 :
                       cmd.hash_step ? step_reg + STEP_W'(1) : step_reg;

    assign home    = acc_reg[ADDR_W-1:0] ^ acc_reg[MUL_W-1:HASH_SHIFT];
    assign rd_addr = cmd.seed ? home : idx_reg;

    assign rd_used = ram_rdata[ENTRY_W-1];
    assign rd_id   = ram_rdata[KEY_W +: ID_W];
    assign rd_key  = ram_rdata[KEY_W-1:0];

    assign full   = next_id_reg >= ADDR_W'(CAPACITY / 2);
    assign ins_ok = cmd.resolve && !(rd_used && rd_key == key_reg) && insert_reg && !full;

    assign ram_we    = cmd.clear_wr || ins_ok;
    assign ram_waddr = cmd.clear_wr ? clr_addr_reg : last_addr_reg;
    assign ram_wdata = cmd.clear_wr ? '0 : {1'b1, next_id_reg[ID_W-1:0], key_reg};

    assign clr_addr_next  = cmd.clear_wr ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;
    assign next_id_next   = ins_ok ? next_id_reg + ADDR_W'(1) : next_id_reg;
    assign out_valid_next = cmd.load_out ? 1'b1 :
                            (m_ready ? 1'b0 : out_valid_reg);

    irht_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (CAPACITY)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= '0;
            clr_addr_reg  <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            clr_addr_reg  <= clr_addr_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.load_key) begin
            key_reg    <= s_key;
            insert_reg <= s_operation;
            x_reg      <= MUL_W'(key_ext ^ (key_ext >> HASH_SHIFT));
        end
        if (cmd.issue) begin
            last_addr_reg <= rd_addr;
            idx_reg       <= rd_addr + ADDR_W'(1);
        end
        if (cmd.resolve) begin
            if (rd_used && rd_key == key_reg) begin
                res_status_reg <= ST_FOUND;
                res_id_reg     <= rd_id;
            end else if (!insert_reg) begin
                res_status_reg <= ST_ABSENT;
                res_id_reg     <= '0;
            end else if (full) begin
                res_status_reg <= ST_FULL;
                res_id_reg     <= '0;
            end else begin
                res_status_reg <= ST_INSERTED;
                res_id_reg     <= next_id_reg[ID_W-1:0];
            end
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
        end
    end

    assign stat.clr_last  = clr_addr_reg == ADDR_W'(CAPACITY - 1);
    assign stat.hash_last = step_reg == STEP_W'(HASH_STEPS - 1);
    assign stat.used      = rd_used;
    assign stat.hit       = rd_used && rd_key == key_reg;
    assign stat.out_free  = !out_valid_reg || m_ready;

    assign m_valid    = out_valid_reg;
    assign m_status   = out_status_reg;
    assign m_dense_id = out_id_reg;

endmodule

// ===== sv/irht_ctrl.sv =====
// ----------------------------------------------------------------------------
// irht_ctrl: sequencing state machine
// Runs the clearing pass after reset, then steps each beat through hashing,
// probing and result delivery.
// ----------------------------------------------------------------------------
module irht_ctrl
    import irht_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_PROBE = 6'b001000,
        S_CHECK = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_key = 1'b1;
                    state_next   = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last) begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                cmd.seed   = 1'b1;
                cmd.issue  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (stat.hit || !stat.used) begin
                    cmd.resolve = 1'b1;
                    state_next  = S_RESP;
                end else begin
                    cmd.issue = 1'b1;
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;

endmodule

// ===== sv/id_remap_hash_table.sv =====
// ----------------------------------------------------------------------------
// id_remap_hash_table: 63-bit identifier to dense id remapping table
// Each input beat carries a key and an operation, lookup only or lookup with
// insert if absent. Each beat produces exactly one result beat with a status
// (found, inserted, not present, table full) and the dense id of the key.
// Dense ids are handed out in insertion order from zero; an insert is refused
// once half of the 4096 slots are in use.
// The key is hashed by one shared multiplier, after which the slot memory
// is probed linearly, one slot read per cycle. A beat passes from acceptance
// through the hash, probe, check and response states to the result register,
// and the next beat is accepted in the idle state that follows.
// Beats are handled one at a time; the result register lets a new beat be
// accepted while the previous result is still waiting for m_ready.
// After reset a clearing pass marks each of the 4096 slots unused, with
// s_ready held low throughout. A stalled receiver holds the block only once
// a second result is ready to be delivered.
// ----------------------------------------------------------------------------
module id_remap_hash_table
    import irht_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [KEY_W-1:0]    s_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_dense_id
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    irht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    irht_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_operation (s_operation),
        .s_key       (s_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_dense_id  (m_dense_id)
    );

endmodule

// ===== sv/irht_checker.sv =====
// ----------------------------------------------------------------------------
// irht_checker: port-level assertions for the remap hash table
// Checks reset behaviour, one-beat-at-a-time acceptance, the dense id of
// unsuccessful results and the stability of a stalled result beat.
// ----------------------------------------------------------------------------
module irht_checker
    import irht_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [ID_W-1:0]     m_dense_id
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ports not quiet after reset");

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    a_miss_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ABSENT || m_status == ST_FULL) |-> m_dense_id == '0)
        else $error("non-zero dense id on unsuccessful result");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_dense_id))
        else $error("stalled result beat changed");

endmodule

bind id_remap_hash_table irht_checker u_irht_checker (.*);

// ===== dv/remap_check_pkg.sv =====
// ----------------------------------------------------------------------------
// remap_check_pkg: prediction and checking for the identifier remap table
// Holds an independent slot-level model of the open-addressed table: the key
// mixing hash, linear probing with wrap-around, dense id allocation and the
// half-load insert limit. The scoreboard predicts one answer per accepted
// beat and compares each delivered result beat against the oldest answer.
// ----------------------------------------------------------------------------
package remap_check_pkg;

    import irht_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int MIX_SHIFT = 33;
    localparam logic [63:0] MIX_MUL = 64'hff51afd7ed558ccd;
    localparam int REPORT_LIMIT = 10;

    typedef enum bit {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } remap_op_t;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  dense_id;
    } answer_t;

    function automatic logic [SLOT_W-1:0] mix_slot(logic [KEY_W-1:0] key);
        logic [63:0] h;
        h = {1'b0, key};
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_MUL;
        h = h ^ (h >> MIX_SHIFT);
        return h[SLOT_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[KEY_W-1:0];
    endfunction

    // Searches for a key whose home slot lies within span slots from base.
    function automatic logic [KEY_W-1:0] key_near_slot(logic [SLOT_W-1:0] base,
                                                       int unsigned span);
        logic [KEY_W-1:0]  k;
        logic [SLOT_W-1:0] offset;
        do begin
            k = random_key();
            offset = mix_slot(k) - base;
        end while (offset >= span);
        return k;
    endfunction

    class remap_scoreboard;

        logic [KEY_W-1:0] slot_key [];
        logic [ID_W-1:0]  slot_id [];
        bit               slot_used [];
        int unsigned      next_id;
        answer_t          pending_answers [$];
        int unsigned      error_count;
        int unsigned      result_count;

        function new();
            slot_key = new[CAPACITY];
            slot_id = new[CAPACITY];
            slot_used = new[CAPACITY];
            next_id = 0;
            error_count = 0;
            result_count = 0;
        endfunction

        function bit table_full();
            return next_id * 2 >= CAPACITY;
        endfunction

        function int unsigned waiting();
            return pending_answers.size();
        endfunction

        function void note_request(remap_op_t op, logic [KEY_W-1:0] key);
            int unsigned idx;
            int unsigned n;
            answer_t     ans;
            idx = mix_slot(key);
            ans.status = (op == OP_INSERT) ? ST_FULL : ST_ABSENT;
            ans.dense_id = '0;
            for (n = 0; n < CAPACITY; n++) begin
                if (!slot_used[idx]) begin
                    if (op == OP_INSERT && !table_full()) begin
                        slot_key[idx] = key;
                        slot_id[idx] = next_id[ID_W-1:0];
                        slot_used[idx] = 1'b1;
                        ans.status = ST_INSERTED;
                        ans.dense_id = next_id[ID_W-1:0];
                        next_id++;
                    end
                    break;
                end
                if (slot_key[idx] == key) begin
                    ans.status = ST_FOUND;
                    ans.dense_id = slot_id[idx];
                    break;
                end
                idx = (idx + 1) % CAPACITY;
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] dense_id);
            answer_t ans;
            result_count++;
            if (pending_answers.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("ERROR: result beat %0d arrived with nothing outstanding: "
                             , result_count, "status %0d dense_id %0d", status, dense_id);
                end
                return;
            end
            ans = pending_answers.pop_front();
            if (status !== ans.status || dense_id !== ans.dense_id) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("ERROR: result beat %0d: status %0d dense_id %0d, expected "
                             , result_count, status, dense_id,
                             "status %0d dense_id %0d", ans.status, ans.dense_id);
                end
            end
        endfunction

    endclass

endpackage

// ===== dv/id_remap_hash_table_tb.sv =====
// ----------------------------------------------------------------------------
// id_remap_hash_table_tb: self-checking testbench of the identifier remap table
// A directed opening covers the key extremes, both operations, re-insertion of
// stored keys and probe chains that wrap past the last slot. Random traffic
// then loads the table with fresh, clustered and sparse keys mixed with
// lookups. Both channels idle at random, and the receiver holds off once for
// a long stretch to back the block up.
// ----------------------------------------------------------------------------
module id_remap_hash_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import irht_pkg::*;
    import remap_check_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1430;
    localparam int unsigned PHASE_LEN = 480;
    localparam int unsigned HOLD_START = 300;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_operation;
    logic [KEY_W-1:0]    s_key;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [ID_W-1:0]     m_dense_id;

    remap_scoreboard  scoreboard = new();
    logic [KEY_W-1:0] insert_pool [$];
    int unsigned      accepted_items = 0;
    int unsigned      send_idle_pct = 37;
    int unsigned      recv_idle_pct = 45;

    id_remap_hash_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_key       (s_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_dense_id  (m_dense_id)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [KEY_W-1:0] known_key();
        if (insert_pool.size() == 0) begin
            return random_key();
        end
        return insert_pool[$urandom_range(insert_pool.size() - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15 && insert_pool.size() != 0) begin
            return key_near_slot(mix_slot(known_key()), 16);
        end else if (pick < 19) begin
            return KEY_W'(1) << $urandom_range(KEY_W - 1);
        end else if (pick < 22) begin
            return ~(KEY_W'(1) << $urandom_range(KEY_W - 1));
        end
        return random_key();
    endfunction

    task automatic send_item(remap_op_t op, logic [KEY_W-1:0] key);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_key <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scoreboard.note_request(op, key);
        accepted_items++;
        if (op == OP_INSERT) begin
            insert_pool.push_back(key);
        end
    endtask

    // Result side: checks delivered beats and paces m_ready, including one long hold-off.
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                scoreboard.check_result(m_status, m_dense_id);
            end
            if (!hold_done && accepted_items >= HOLD_START) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] edge_keys [4];
        logic [KEY_W-1:0] key;
        remap_op_t        op;
        int unsigned      rand_done;
        int unsigned      pick;
        bit               full;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_operation <= OP_LOOKUP;
        s_key <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(OP_LOOKUP, '0);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_LOOKUP, '0);
        send_item(OP_LOOKUP, KEY_MAX);
        send_item(OP_INSERT, '0);
        send_item(OP_LOOKUP, 63'h5555_5555_5555_5555);
        send_item(OP_INSERT, 63'h2aaa_aaaa_aaaa_aaaa);
        send_item(OP_LOOKUP, 63'h2aaa_aaaa_aaaa_aaaa);

        // Keys homed on the last slot force probe chains across the wrap.
        for (int i = 0; i < 4; i++) begin
            edge_keys[i] = key_near_slot(SLOT_W'(CAPACITY - 1), 1);
        end
        for (int i = 0; i < 3; i++) begin
            send_item(OP_INSERT, edge_keys[i]);
        end
        for (int i = 0; i < 3; i++) begin
            send_item(OP_LOOKUP, edge_keys[i]);
        end
        send_item(OP_LOOKUP, edge_keys[3]);
        send_item(OP_INSERT, edge_keys[3]);
        send_item(OP_INSERT, edge_keys[1]);
        send_item(OP_LOOKUP, edge_keys[3]);

        rand_done = 0;
        while (rand_done < RANDOM_ITEMS) begin
            if (rand_done == PHASE_LEN) begin
                send_idle_pct = 45;
                recv_idle_pct = 37;
            end else if (rand_done == 2 * PHASE_LEN) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            full = scoreboard.table_full();
            pick = $urandom_range(99);
            if (pick < (full ? 35 : 80)) begin
                op = OP_INSERT;
                key = fresh_key();
            end else if (pick < (full ? 60 : 87)) begin
                op = OP_INSERT;
                key = known_key();
            end else if (pick < (full ? 85 : 94)) begin
                op = OP_LOOKUP;
                key = known_key();
            end else begin
                op = OP_LOOKUP;
                key = random_key();
            end
            send_item(op, key);
            rand_done++;
        end

        s_valid <= 1'b0;
        while (scoreboard.waiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scoreboard.error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
